@@ hdl/rmf_pkg.sv @@
// Shared types and constants for the running median filter.
package rmf_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;
    localparam int POS_W  = 16;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd5;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // take the input word, restart the sorter
        logic next_n;   // advance to the next median position, restart the sorter
        logic step;     // one fetch / insert step
        logic capture;  // latch the median into the output register
    } rmf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic has_result;
        logic load_done;
        logic more;
    } rmf_status_t;

endpackage

@@ hdl/rmf_if.sv @@
// Stream and configuration channel interfaces of the running median filter.
interface rmf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [rmf_pkg::DATA_W-1:0]   sample;
    logic                                last_in_slice;
    modport source (output valid, sample, last_in_slice, input ready);
    modport sink   (input valid, sample, last_in_slice, output ready);
endinterface

interface rmf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rmf_pkg::DATA_W-1:0]   median;
    logic                                last_of_run;
    modport source (output valid, median, last_of_run, input ready);
    modport sink   (input valid, median, last_of_run, output ready);
endinterface

interface rmf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rmf_pkg::CFG_W-1:0]       window_length;
    modport source (output valid, window_length, input ready);
    modport sink   (input valid, window_length, output ready);
endinterface

@@ hdl/rmf_datapath.sv @@
// Datapath: sample history, head copy, insertion sorter and output register.
module rmf_datapath #(
    parameter int WIN_CAP = 31
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rmf_pkg::rmf_cmd_t                 cmd,
    output rmf_pkg::rmf_status_t              st,
    input  logic signed [rmf_pkg::DATA_W-1:0] in_sample,
    input  logic                              in_last,
    input  logic                              cfg_valid,
    input  logic [rmf_pkg::CFG_W-1:0]         cfg_data,
    output logic signed [rmf_pkg::DATA_W-1:0] median,
    output logic                              last_of_run
);
    localparam int CW  = $clog2(WIN_CAP + 1);
    localparam int IW  = $clog2(WIN_CAP);
    localparam int HD  = (WIN_CAP - 1) / 2;
    localparam int HIW = (HD > 1) ? $clog2(HD) : 1;
    localparam int PW  = rmf_pkg::POS_W;
    localparam int DW  = rmf_pkg::DATA_W;

    logic [rmf_pkg::CFG_W-1:0] window_length_reg;
    logic [CW-1:0]             active_w_reg, half_reg, k_reg, fill_reg;
    logic [PW-1:0]             pos_reg, p_reg, n_reg;
    logic                      last_reg, has_res_reg, fv_reg, lor_reg;
    logic signed [DW-1:0]      f_reg, median_reg;
    logic signed [DW-1:0]      recent_reg [WIN_CAP];
    logic signed [DW-1:0]      head_reg   [HD];
    logic signed [DW-1:0]      cells_reg  [WIN_CAP];
    logic signed [DW-1:0]      cells_next [WIN_CAP];

    logic [rmf_pkg::CFG_W-1:0] w_odd;
    logic [CW-1:0]             w_cfg, w_use, h_use;
    logic [PW:0]               pos_inc;
    logic [PW+1:0]             idx, h18, len, j, age;
    logic signed [DW-1:0]      fetched;
    logic                      restart;

    function automatic logic [rmf_pkg::CFG_W-1:0] cfg_data_q(
        input logic [rmf_pkg::CFG_W-1:0] v);
        return v | rmf_pkg::CFG_W'(1);
    endfunction

    // window from register: round up to odd, clamp to capacity
    assign w_odd = cfg_data_q(window_length_reg);
    assign w_cfg = ({1'b0, w_odd} > (rmf_pkg::CFG_W+1)'(WIN_CAP)) ? CW'(WIN_CAP) : CW'(w_odd);
    assign w_use = (pos_reg == '0) ? w_cfg : active_w_reg;
    assign h_use = w_use >> 1;
    assign pos_inc = {1'b0, pos_reg} + (PW+1)'(1);
    assign restart = cmd.accept | cmd.next_n;

    // padded index -> slice index -> stored sample
    always_comb
    begin
        idx = (PW+2)'(n_reg) + (PW+2)'(k_reg);
        h18 = (PW+2)'(half_reg);
        len = (PW+2)'(p_reg) + (PW+2)'(1);
        if (idx < h18)
            j = (idx < len) ? idx : (PW+2)'(p_reg);
        else if (idx < h18 + len)
            j = idx - h18;
        else if (idx >= (h18 << 1))
            j = idx - (h18 << 1);
        else
            j = '0;
        age = (PW+2)'(p_reg) - j;
        if (age < (PW+2)'(active_w_reg))
            fetched = recent_reg[age[IW-1:0]];
        else if (j < (PW+2)'(HD))
            fetched = head_reg[j[HIW-1:0]];
        else
            fetched = '0;
    end

    // one insertion step over all cells; equal values stay ahead of the new one
    for (genvar i = 0; i < WIN_CAP; i++)
    begin : g_cell
        logic keep, shift;
        assign keep = (CW'(i) < fill_reg) && (cells_reg[i] <= f_reg);
        if (i == 0)
        begin : g_first
            assign shift = 1'b0;
        end
        else
        begin : g_rest
            assign shift = (CW'(i - 1) < fill_reg) && (cells_reg[i-1] > f_reg);
        end
        if (i == 0)
        begin : g_first_v
            assign cells_next[i] = keep ? cells_reg[i] : f_reg;
        end
        else
        begin : g_rest_v
            assign cells_next[i] = keep ? cells_reg[i] : (shift ? cells_reg[i-1] : f_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= rmf_pkg::WINDOW_RESET;
            active_w_reg      <= CW'(5);
            pos_reg           <= '0;
            fv_reg            <= 1'b0;
            k_reg             <= '0;
            fill_reg          <= '0;
        end
        else
        begin
            if (cfg_valid)
                window_length_reg <= cfg_data;
            if (cmd.accept)
            begin
                active_w_reg <= w_use;
                if (in_last)
                    pos_reg <= '0;
                else if (pos_reg != rmf_pkg::POS_MAX)
                    pos_reg <= pos_inc[PW-1:0];
            end
            if (restart)
            begin
                k_reg    <= '0;
                fill_reg <= '0;
                fv_reg   <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (k_reg < active_w_reg)
                begin
                    fv_reg <= 1'b1;
                    k_reg  <= k_reg + CW'(1);
                end
                else
                    fv_reg <= 1'b0;
                if (fv_reg)
                    fill_reg <= fill_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int a = WIN_CAP - 1; a > 0; a--)
                recent_reg[a] <= recent_reg[a-1];
            recent_reg[0] <= in_sample;
            if (pos_reg < PW'(h_use) && pos_reg < PW'(HD))
                head_reg[pos_reg[HIW-1:0]] <= in_sample;
            half_reg    <= h_use;
            p_reg       <= pos_reg;
            last_reg    <= in_last;
            has_res_reg <= in_last || (pos_reg >= PW'(h_use));
            n_reg       <= (pos_reg >= PW'(h_use)) ? pos_reg - PW'(h_use) : '0;
        end
        else if (cmd.next_n)
            n_reg <= n_reg + PW'(1);
        if (cmd.step && !restart)
        begin
            if (k_reg < active_w_reg)
                f_reg <= fetched;
            if (fv_reg)
                cells_reg <= cells_next;
        end
        if (cmd.capture)
        begin
            median_reg <= cells_reg[half_reg[IW-1:0]];
            lor_reg    <= last_reg && (n_reg == p_reg);
        end
    end

    assign st.has_result = has_res_reg;
    assign st.load_done  = (k_reg == active_w_reg) && !fv_reg;
    assign st.more       = last_reg && (n_reg != p_reg);
    assign median        = median_reg;
    assign last_of_run   = lor_reg;

endmodule

@@ hdl/rmf_ctrl.sv @@
// Controller: sequences accept, window load, and result handoff.
module rmf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rmf_pkg::rmf_cmd_t    cmd,
    input  rmf_pkg::rmf_status_t st
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!st.has_result)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.step = 1'b1;
                    if (st.load_done)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (st.more)
                    begin
                        cmd.next_n = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_LOAD))
        else $error("accepted word did not start a load");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && (state_reg == ST_EMIT)))
        else $error("pending median dropped");
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !st.more) |=> (state_reg == ST_IDLE))
        else $error("slice end did not return to idle");

endmodule

@@ hdl/running_median_filter_core.sv @@
// Top level of the running median filter.
// One slice arrives one sample word at a time, closed by last_in_slice. For each
// position the core emits the median of an odd window (window_length rounded up
// to odd, capped at the build capacity) over the slice padded at both ends with
// copies of its first and last half-window samples; medians lag by half a window,
// and the last word flushes up to half-window + 1 remaining medians. The register
// is sampled at the first word of each slice. Items are handled one at a time:
// for each median the insertion sorter runs W fetch/insert steps, one pipeline
// slot and one capture, and the median is then held until the output handoff;
// a word that produces no median goes from the load state straight back to idle.
module running_median_filter_core #(
    parameter int MAX_WINDOW = 31
) (
    input  logic      clk,
    input  logic      rst_n,
    rmf_in_if.sink    samples,
    rmf_out_if.source medians,
    rmf_cfg_if.sink   cfg
);
    localparam int CAP_RAW = (MAX_WINDOW > 31) ? 31 : MAX_WINDOW;
    localparam int WIN_CAP = (CAP_RAW % 2 == 0) ? CAP_RAW - 1 : CAP_RAW;

    rmf_pkg::rmf_cmd_t    cmd;
    rmf_pkg::rmf_status_t st;

    // register write is always taken; writes are only to be made while idle, which the block does not enforce
    assign cfg.ready = 1'b1;

    rmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (medians.valid),
        .out_ready (medians.ready),
        .cmd       (cmd),
        .st        (st)
    );

    rmf_datapath #(
        .WIN_CAP (WIN_CAP)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_sample   (samples.sample),
        .in_last     (samples.last_in_slice),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.window_length),
        .median      (medians.median),
        .last_of_run (medians.last_of_run)
    );

endmodule

@@ verif/tb_running_median_filter_core.sv @@
// Testbench for running_median_filter_core: random and directed slices vs a median model.
`timescale 1ns / 100ps

module tb_running_median_filter_core;

    localparam int HALF_MAX = 15;
    localparam int SETTLE   = 60;   // lets a word still in flight finish

    typedef struct packed {
        logic signed [rmf_pkg::DATA_W-1:0] median;
        logic                              last_of_run;
    } median_word_t;

    logic clk;
    logic rst_n;

    rmf_in_if  in_ch ();
    rmf_out_if out_ch ();
    rmf_cfg_if cfg_ch ();

    running_median_filter_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_ch.sink),
        .medians (out_ch.source),
        .cfg     (cfg_ch.sink)
    );

    // predictor state
    logic [rmf_pkg::CFG_W-1:0]         window_reg;
    logic signed [rmf_pkg::DATA_W-1:0] recent [31];
    logic signed [rmf_pkg::DATA_W-1:0] head [HALF_MAX];
    logic [rmf_pkg::POS_W-1:0]         slice_pos;
    int                                active_w;

    median_word_t median_q [$];
    int           fail_count;
    int           src_idle_pct;
    int           snk_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("tb_running_median_filter_core: FAIL");
        $finish;
    end

    // odd window from the register, capped at 31
    function automatic int odd_window(logic [rmf_pkg::CFG_W-1:0] wl);
        int w;
        w = int'(wl);
        if ((w & 1) == 0)
            w = w + 1;
        if (w > 31)
            w = 31;
        return w;
    endfunction

    // sample j of the slice, p is the index of the newest sample
    function automatic logic signed [rmf_pkg::DATA_W-1:0] slice_sample(int j, int p);
        int age;
        age = p - j;
        if (age >= 0 && age < active_w && age < 31)
            return recent[age];
        if (j >= 0 && j < HALF_MAX)
            return head[j];
        return '0;
    endfunction

    // median of the padded window starting at padded index n
    function automatic logic signed [rmf_pkg::DATA_W-1:0] window_median(
        int n, int p, int len, int half);
        logic signed [rmf_pkg::DATA_W-1:0] vals [31];
        logic signed [rmf_pkg::DATA_W-1:0] v;
        int i, j, m;
        for (int k = 0; k < 2 * half + 1; k++)
        begin
            i = n + k;
            if (i < half)
                j = (i < len) ? i : len - 1;
            else if (i < half + len)
                j = i - half;
            else
            begin
                j = i - 2 * half;
                if (j < 0)
                    j = 0;
            end
            v = slice_sample(j, p);
            m = k;
            while (m > 0 && vals[m-1] > v)
            begin
                vals[m] = vals[m-1];
                m--;
            end
            vals[m] = v;
        end
        return vals[half];
    endfunction

    // advance the predictor by one accepted word and queue its medians
    task automatic predict_word(logic signed [rmf_pkg::DATA_W-1:0] x, logic last);
        int half, p, first;
        median_word_t mw;
        if (slice_pos == 0)
            active_w = odd_window(window_reg);
        half = (active_w - 1) / 2;
        p    = int'(slice_pos);
        for (int k = 30; k > 0; k--)
            recent[k] = recent[k-1];
        recent[0] = x;
        if (p < half && p < HALF_MAX)
            head[p] = x;
        if (!last)
        begin
            if (p >= half)
            begin
                mw.median      = window_median(p - half, p, p + 1, half);
                mw.last_of_run = 1'b0;
                median_q.push_back(mw);
            end
            if (slice_pos != rmf_pkg::POS_MAX)
                slice_pos++;
        end
        else
        begin
            first = (p - half < 0) ? 0 : p - half;
            for (int n = first; n <= p; n++)
            begin
                mw.median      = window_median(n, p, p + 1, half);
                mw.last_of_run = (n == p);
                median_q.push_back(mw);
            end
            slice_pos = '0;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (median_q.size() == 0)
            begin
                $display("%0t: unexpected median word %h last %b", $time,
                         out_ch.median, out_ch.last_of_run);
                fail_count++;
            end
            else
            begin
                if (out_ch.median !== median_q[0].median
                    || out_ch.last_of_run !== median_q[0].last_of_run)
                begin
                    $display("%0t: expected median %h last %b, got median %h last %b",
                             $time, median_q[0].median, median_q[0].last_of_run,
                             out_ch.median, out_ch.last_of_run);
                    fail_count++;
                end
                void'(median_q.pop_front());
            end
        end
    end

    // receiver backpressure
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

    task automatic send_word(logic signed [rmf_pkg::DATA_W-1:0] x, logic last);
        while ($urandom_range(99) < src_idle_pct)
            @(negedge clk);
        in_ch.valid         = 1'b1;
        in_ch.sample        = x;
        in_ch.last_in_slice = last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_word(x, last);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (median_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_window(logic [rmf_pkg::CFG_W-1:0] wl);
        drain();
        cfg_ch.valid         = 1'b1;
        cfg_ch.window_length = wl;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        window_reg = wl;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_slice(int len, logic signed [rmf_pkg::DATA_W-1:0] lo,
                              logic signed [rmf_pkg::DATA_W-1:0] hi);
        logic signed [rmf_pkg::DATA_W-1:0] x;
        for (int i = 0; i < len; i++)
        begin
            if (lo == hi)
                x = $urandom;
            else
                x = lo + $signed($urandom_range(int'(hi - lo)));
            send_word(x, i == len - 1);
        end
    endtask

    // extreme values, ties and the default window
    task automatic test_extremes();
        send_word(32'sh7fffffff, 1'b0);
        send_word(32'sh80000000, 1'b0);
        send_word(32'sh00000000, 1'b0);
        send_word(32'sh00000000, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sh7fffffff, 1'b0);
        send_word(32'sh80000000, 1'b1);
    endtask

    // slices shorter than the half window, including a single word, and even window values rounded up
    task automatic test_short_slices();
        write_window(5'd31);
        send_word(32'sh00010000, 1'b1);
        send_word(32'sh12345678, 1'b0);
        send_word(-32'sh00020000, 1'b0);
        send_word(32'sh7fffffff, 1'b1);
        write_window(5'd0);
        send_slice(3, 0, 0);
        write_window(5'd2);
        send_slice(2, 0, 0);
    endtask

    // register written mid-slice only applies at the next slice
    task automatic test_midslice_write();
        write_window(5'd7);
        send_slice(4, -5, 5);
        send_word(32'sh00000003, 1'b0);
        write_window(5'd1);
        send_word(32'sh00000004, 1'b0);
        send_word(32'sh00000002, 1'b1);
        send_slice(3, -5, 5);
    endtask

    // random slices and windows under the idling phases
    task automatic test_random();
        int words;
        int phase;
        words = 0;
        phase = 0;
        while (words < 80)
        begin
            case (phase % 4)
                0:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 70;
                    snk_idle_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 70;
                end
                default:
                begin
                    src_idle_pct = 34;
                    snk_idle_pct = 34;
                end
            endcase
            phase++;
            write_window(5'($urandom_range(31)));
            for (int s = 0; s < 2; s++)
            begin
                int len;
                len = $urandom_range(1, 12);
                if ($urandom_range(1))
                    send_slice(len, 0, 0);
                else
                    send_slice(len, -3, 3);
                words += len;
            end
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.sample         = '0;
        in_ch.last_in_slice  = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.window_length = rmf_pkg::WINDOW_RESET;
        src_idle_pct         = 0;
        snk_idle_pct         = 0;
        fail_count           = 0;
        window_reg           = rmf_pkg::WINDOW_RESET;
        slice_pos            = '0;
        active_w             = 5;
        for (int k = 0; k < 31; k++)
            recent[k] = '0;
        for (int k = 0; k < HALF_MAX; k++)
            head[k] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_short_slices();
        test_midslice_write();
        test_random();
        write_window(5'd31);
        send_slice(17, 0, 0);
        drain();

        if (fail_count == 0)
            $display("tb_running_median_filter_core: PASS");
        else
            $display("tb_running_median_filter_core: FAIL");
        $finish;
    end

endmodule
